[rtl/core/button_rgb_led_color_setter_core_macros.svh]
// Assertion helpers used by the checker file.
`ifndef BUTTON_RGB_LED_COLOR_SETTER_CORE_MACROS_SVH
`define BUTTON_RGB_LED_COLOR_SETTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRLCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brlcs assertion failed");

// Next-cycle implication, disabled during reset.
`define BRLCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brlcs assertion failed");

`endif

[rtl/core/brlcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package brlcs_pkg;

   localparam logic [2:0] KEY_UP    = 3'd0;
   localparam logic [2:0] KEY_DOWN  = 3'd1;
   localparam logic [2:0] KEY_RIGHT = 3'd2;
   localparam logic [2:0] KEY_LEFT  = 3'd3;
   localparam logic [2:0] KEY_OK    = 3'd4;
   localparam logic [2:0] KEY_BACK  = 3'd5;

   localparam logic [2:0] EV_PRESS  = 3'd0;
   localparam logic [2:0] EV_SHORT  = 3'd2;
   localparam logic [2:0] EV_LONG   = 3'd3;
   localparam logic [2:0] EV_REPEAT = 3'd4;

   localparam logic [1:0] CH_RED    = 2'd0;
   localparam logic [1:0] CH_GREEN  = 2'd1;
   localparam logic [1:0] CH_BLUE   = 2'd2;
   localparam logic [1:0] CH_UNUSED = 2'd3;

   localparam logic CSR_FINE_STEP = 1'b0;
   localparam logic CSR_FAST_STEP = 1'b1;

   localparam logic [7:0] FINE_STEP_RESET = 8'd1;
   localparam logic [7:0] FAST_STEP_RESET = 8'd5;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type    level;
      logic [1:0] chan;
      logic [3:0] preset;
      logic       led_on;
   } state_type;

   typedef struct packed {
      logic refresh_led;
      logic refresh_view;
      logic exit_request;
   } flags_type;

   localparam state_type STATE_RESET = '{
      level:  '{red: 8'd255, green: 8'd0, blue: 8'd0},
      chan:   CH_RED,
      preset: 4'd0,
      led_on: 1'b1
   };

   // Fixed preset colors; entries past the ninth are black.
   function automatic rgb_type preset_colour(input logic [3:0] idx);
      rgb_type c;
      unique case (idx)
         4'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         4'd1:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
         4'd2:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
         4'd3:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         4'd4:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
         4'd5:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
         4'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
         4'd7:    c = '{red: 8'd255, green: 8'd80,  blue: 8'd0};
         4'd8:    c = '{red: 8'd128, green: 8'd0,   blue: 8'd255};
         default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/brlcs_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface brlcs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] key_code;
   logic [2:0] event_kind;

   modport source (output valid, output key_code, output event_kind, input ready);
   modport sink   (input valid, input key_code, input event_kind, output ready);
endinterface

interface brlcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] drive_red;
   logic [7:0] drive_green;
   logic [7:0] drive_blue;
   logic [1:0] channel_now;
   logic [3:0] preset_now;
   logic       enabled_now;
   logic       refresh_led;
   logic       refresh_view;
   logic       exit_request;

   modport source (
      output valid, output drive_red, output drive_green, output drive_blue,
      output channel_now, output preset_now, output enabled_now,
      output refresh_led, output refresh_view, output exit_request,
      input ready
   );
   modport sink (
      input valid, input drive_red, input drive_green, input drive_blue,
      input channel_now, input preset_now, input enabled_now,
      input refresh_led, input refresh_view, input exit_request,
      output ready
   );
endinterface

`default_nettype wire

[rtl/core/brlcs_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

module brlcs_eval
   import brlcs_pkg::*;
#(
   parameter int unsigned NUM_PRESETS = 9
) (
   input  logic [2:0] key_code,
   input  logic [2:0] event_kind,
   input  logic [7:0] fine_step,
   input  logic [7:0] fast_step,
   input  state_type  cur,
   output state_type  nxt,
   output flags_type  flags
);

   localparam logic [3:0] CUSTOM_IDX = 4'(NUM_PRESETS);
   localparam logic [3:0] LAST_IDX   = 4'(NUM_PRESETS - 1);

   logic       press;
   logic [7:0] step;
   logic [7:0] old_level;
   logic [7:0] new_level;
   logic [8:0] sum;
   logic       changed;
   logic [3:0] next_idx;
   rgb_type    colour;

   always_comb begin
      press = (event_kind == EV_PRESS);
      step  = press ? fine_step : fast_step;

      case (cur.chan)
         CH_GREEN: old_level = cur.level.green;
         CH_BLUE:  old_level = cur.level.blue;
         default:  old_level = cur.level.red;
      endcase

      sum = {1'b0, old_level} + {1'b0, step};
      if (key_code == KEY_UP) begin
         new_level = sum[8] ? 8'hFF : sum[7:0];
      end else begin
         new_level = (old_level < step) ? 8'd0 : old_level - step;
      end
      changed = (new_level != old_level);

      // From custom, or from the last table entry, the next preset is the first one.
      if (cur.preset >= LAST_IDX) begin
         next_idx = 4'd0;
      end else begin
         next_idx = cur.preset + 4'd1;
      end
      colour = preset_colour(next_idx);
   end

   always_comb begin
      nxt   = cur;
      flags = '0;
      if (event_kind == EV_PRESS || event_kind == EV_REPEAT) begin
         case (key_code) inside
            KEY_LEFT: begin
               if (press) begin
                  nxt.chan = (cur.chan == CH_RED) ? CH_BLUE : cur.chan - 2'd1;
                  flags.refresh_view = 1'b1;
               end
            end
            KEY_RIGHT: begin
               if (press) begin
                  nxt.chan = (cur.chan == CH_BLUE || cur.chan == CH_UNUSED) ?
                             CH_RED : cur.chan + 2'd1;
                  flags.refresh_view = 1'b1;
               end
            end
            KEY_UP, KEY_DOWN: begin
               if (changed) begin
                  case (cur.chan)
                     CH_GREEN: nxt.level.green = new_level;
                     CH_BLUE:  nxt.level.blue  = new_level;
                     default:  nxt.level.red   = new_level;
                  endcase
                  nxt.preset         = CUSTOM_IDX;
                  flags.refresh_led  = 1'b1;
                  flags.refresh_view = 1'b1;
               end
            end
            KEY_BACK: begin
               flags.exit_request = press;
            end
            default: begin
            end
         endcase
      end else if (event_kind == EV_SHORT && key_code == KEY_OK) begin
         nxt.preset         = next_idx;
         nxt.level          = colour;
         nxt.led_on         = 1'b1;
         flags.refresh_led  = 1'b1;
         flags.refresh_view = 1'b1;
      end else if (event_kind == EV_LONG && key_code == KEY_OK) begin
         nxt.led_on         = ~cur.led_on;
         flags.refresh_led  = 1'b1;
         flags.refresh_view = 1'b1;
      end
   end

endmodule

`default_nettype wire

[rtl/core/button_rgb_led_color_setter_core.sv]
// Each result passes the input register, then the result register, and is held there
// while the result side stalls. Throughput: one key event per cycle unless the result
// side stalls, limited by the state update loop.
// Reset (synchronous, active high) empties both stages, restores red at full level,
// channel red, preset 0, LED enabled, fine step 1 and fast step 5.
`timescale 1ns / 1ps
`default_nettype none

module button_rgb_led_color_setter_core
   import brlcs_pkg::*;
#(
   parameter int unsigned NUM_PRESETS = 9
) (
   input  logic        clock,
   input  logic        reset,
   brlcs_req_if.sink   req_ch,
   brlcs_rsp_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_key_ff, s1_kind_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] fine_step_ff, fast_step_ff;
   state_type  state_ff, state_nxt;
   flags_type  flags;
   state_type  res_state_ff;
   flags_type  res_flags_ff;
   logic       advance;
   logic       take_in;

   brlcs_eval #(.NUM_PRESETS(NUM_PRESETS)) u_eval (
      .key_code   (s1_key_ff),
      .event_kind (s1_kind_ff),
      .fine_step  (fine_step_ff),
      .fast_step  (fast_step_ff),
      .cur        (state_ff),
      .nxt        (state_nxt),
      .flags      (flags)
   );

   // The evaluated item moves into the result register when it is empty or being drained.
   always_comb begin
      advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
      req_ch.ready = !s1_valid_ff || advance;
      take_in      = req_ch.valid && req_ch.ready;
      s1_valid_in  = take_in || (s1_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         fine_step_ff <= FINE_STEP_RESET;
         fast_step_ff <= FAST_STEP_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FINE_STEP: fine_step_ff <= csr_wdata;
               CSR_FAST_STEP: fast_step_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_key_ff  <= req_ch.key_code;
         s1_kind_ff <= req_ch.event_kind;
      end
      if (advance) begin
         res_state_ff <= state_nxt;
         res_flags_ff <= flags;
      end
   end

   always_comb begin
      rsp_ch.valid        = out_valid_ff;
      rsp_ch.drive_red    = res_state_ff.led_on ? res_state_ff.level.red   : 8'd0;
      rsp_ch.drive_green  = res_state_ff.led_on ? res_state_ff.level.green : 8'd0;
      rsp_ch.drive_blue   = res_state_ff.led_on ? res_state_ff.level.blue  : 8'd0;
      rsp_ch.channel_now  = res_state_ff.chan;
      rsp_ch.preset_now   = res_state_ff.preset;
      rsp_ch.enabled_now  = res_state_ff.led_on;
      rsp_ch.refresh_led  = res_flags_ff.refresh_led;
      rsp_ch.refresh_view = res_flags_ff.refresh_view;
      rsp_ch.exit_request = res_flags_ff.exit_request;
   end

endmodule

`default_nettype wire

[rtl/core/brlcs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "button_rgb_led_color_setter_core_macros.svh"

module brlcs_checker
   import brlcs_pkg::*;
#(
   parameter int unsigned NUM_PRESETS = 9
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_drive_red,
   input wire logic [7:0] rsp_drive_green,
   input wire logic [7:0] rsp_drive_blue,
   input wire logic [1:0] rsp_channel_now,
   input wire logic [3:0] rsp_preset_now,
   input wire logic       rsp_enabled_now,
   input wire logic       rsp_refresh_led,
   input wire logic       rsp_refresh_view,
   input wire logic       rsp_exit_request
);

   logic [33:0] rsp_payload;
   logic        rsp_stalled;
   logic        rsp_dark;
   logic        rsp_flagged;
   logic        rsp_flags_ok;
   logic        rsp_in_range;

   assign rsp_payload  = {rsp_drive_red, rsp_drive_green, rsp_drive_blue, rsp_channel_now,
                          rsp_preset_now, rsp_enabled_now, rsp_refresh_led,
                          rsp_refresh_view, rsp_exit_request};
   assign rsp_stalled  = rsp_valid && !rsp_ready;
   assign rsp_dark     = (rsp_drive_red == 8'd0) && (rsp_drive_green == 8'd0) &&
                         (rsp_drive_blue == 8'd0);
   assign rsp_flagged  = rsp_valid && (rsp_refresh_led || rsp_exit_request);
   assign rsp_flags_ok = (rsp_refresh_view != rsp_exit_request);
   assign rsp_in_range = (rsp_channel_now != CH_UNUSED) &&
                         (rsp_preset_now <= 4'(NUM_PRESETS));

   // A stalled result must hold until its transfer.
   `BRLCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

   // A disabled LED is driven dark.
   `BRLCS_ASSERT_IMP(a_dark_when_off, clock, reset, rsp_valid && !rsp_enabled_now, rsp_dark)

   // Every LED refresh also redraws the view, and an exit request does not redraw the view.
   `BRLCS_ASSERT_IMP(a_refresh_flags, clock, reset, rsp_flagged, rsp_flags_ok)

   // The channel never reaches the unused code and the preset never passes custom.
   `BRLCS_ASSERT_IMP(a_state_range, clock, reset, rsp_valid, rsp_in_range)

endmodule

bind button_rgb_led_color_setter_core
   brlcs_checker #(.NUM_PRESETS(NUM_PRESETS)) u_brlcs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_drive_red    (rsp_ch.drive_red),
   .rsp_drive_green  (rsp_ch.drive_green),
   .rsp_drive_blue   (rsp_ch.drive_blue),
   .rsp_channel_now  (rsp_ch.channel_now),
   .rsp_preset_now   (rsp_ch.preset_now),
   .rsp_enabled_now  (rsp_ch.enabled_now),
   .rsp_refresh_led  (rsp_ch.refresh_led),
   .rsp_refresh_view (rsp_ch.refresh_view),
   .rsp_exit_request (rsp_ch.exit_request)
);

`default_nettype wire
